/* design/etc_pkg.sv */
// shared types for the eased tween channel block: request, result and channel record
// no dependencies; every other file of the block but etc_ram imports this package
package etc_pkg;

	localparam int CHANNELS_DEF      = 8;
	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int FRACTION_BITS_DEF = 16;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_SNAP  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                opcode;
		logic [2:0]         channel;
		logic signed [31:0] start_value;
		logic signed [31:0] end_value;
		logic [23:0]        duration_us;
		logic [2:0]         curve_kind;
		logic [23:0]        delta_us;
	} req_t;

	typedef struct packed {
		logic [2:0]         channel_out;
		logic signed [31:0] level;
		logic               is_running;
		logic               just_finished;
	} rsp_t;

	// one channel as it sits in the state memory
	typedef struct packed {
		logic signed [31:0] start_level;
		logic signed [31:0] end_level;
		logic signed [31:0] present_level;
		logic [23:0]        length_us;
		logic [23:0]        passed_us;
		logic               running;
		logic [2:0]         curve;
	} chan_t;

endpackage

/* design/eased_tween_channels.sv */
// Bank of CHANNELS tween channels with easing curves (linear, out-quad, in-out-cubic,
// out-bounce, out-elastic), levels in Q16.16. Each request names a channel and an
// opcode (tick, start, stop, snap) and yields one response with the channel's level,
// its running flag and whether this tick finished it. Requests are handled one at a
// time: start, stop, snap and ticks on idle channels go from acceptance through lookup
// to write-back and response; a tick that lands mid-tween also passes through the
// bit-serial divider forming t and the easing multiply chain. Channel state lives
// in one memory read and written back per request; it reads as zero until written.
// Channel numbers at or above CHANNELS are answered with a zero level and change nothing.
// Depends on etc_pkg, etc_ram, etc_div and etc_ease.
module eased_tween_channels import etc_pkg::*; #(
	parameter int CHANNELS      = CHANNELS_DEF,
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	output logic req_stall,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_stall
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW = $bits(chan_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_DIV,
		S_EASE,
		S_DONE
	} state_t;

	state_t              state_q;
	req_t                req_q;
	chan_t               rec_q;
	logic                fin_q;
	logic                ign_q;
	logic [(1<<AW)-1:0]  vld_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic [CW-1:0]            ram_rdata;
	logic                     ram_we;
	logic [AW-1:0]            addr_q;
	logic                     slot_free;
	chan_t                    rd_rec;
	chan_t                    look_rec;
	logic                     look_fin;
	logic                     look_div;
	logic [24:0]              p_sum;
	logic [23:0]              p_clip;
	logic                     div_start;
	logic                     div_done;
	logic [FRACTION_BITS-1:0] div_quot;
	logic                     ease_start;
	logic                     ease_done;
	logic signed [31:0]       ease_level;

	assign req_stall = (state_q != S_IDLE);
	assign addr_q    = AW'(req_q.channel);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign ram_we    = (state_q == S_DONE) && slot_free && !ign_q;

	etc_ram #(
		.WIDTH (CW),
		.DEPTH (CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (rec_q),
		.re    (req_valid && !req_stall),
		.raddr (AW'(req.channel)),
		.rdata (ram_rdata)
	);

	always_comb begin
		rd_rec   = vld_q[addr_q] ? chan_t'(ram_rdata) : '0;
		look_rec = rd_rec;
		look_fin = 1'b0;
		look_div = 1'b0;
		p_sum    = 25'(rd_rec.passed_us) + 25'(req_q.delta_us);
		p_clip   = (p_sum > 25'(rd_rec.length_us)) ? rd_rec.length_us : p_sum[23:0];
		case (req_q.opcode)
			OP_TICK: begin
				if (rd_rec.running) begin
					look_rec.passed_us = p_clip;
					if (p_clip >= rd_rec.length_us) begin
						look_rec.present_level = rd_rec.end_level;
						look_rec.running       = 1'b0;
						look_fin               = 1'b1;
					end else begin
						look_div = 1'b1;
					end
				end
			end
			OP_START: begin
				look_rec.start_level   = req_q.start_value;
				look_rec.end_level     = req_q.end_value;
				look_rec.present_level = req_q.start_value;
				look_rec.length_us     = req_q.duration_us;
				look_rec.passed_us     = '0;
				look_rec.running       = 1'b1;
				look_rec.curve         = req_q.curve_kind;
			end
			OP_STOP: begin
				look_rec.running = 1'b0;
			end
			OP_SNAP: begin
				look_rec.start_level   = req_q.start_value;
				look_rec.end_level     = req_q.start_value;
				look_rec.present_level = req_q.start_value;
				look_rec.passed_us     = '0;
				look_rec.running       = 1'b0;
			end
			default: ;
		endcase
	end

	assign div_start  = (state_q == S_LOOK) && !ign_q && look_div;
	assign ease_start = (state_q == S_DIV) && div_done;

	etc_div #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (look_rec.passed_us),
		.den    (rd_rec.length_us),
		.done   (div_done),
		.quot   (div_quot)
	);

	etc_ease #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.FRACTION_BITS (FRACTION_BITS)
	) u_ease (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ease_start),
		.t      (div_quot),
		.curve  (rec_q.curve),
		.base   (rec_q.start_level),
		.target (rec_q.end_level),
		.done   (ease_done),
		.level  (ease_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// write-back posts its own response when the slot frees
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						ign_q   <= (7'(req.channel) >= 7'(CHANNELS));
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					rec_q   <= look_rec;
					fin_q   <= look_fin;
					state_q <= div_start ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EASE;
					end
				end
				S_EASE: begin
					if (ease_done) begin
						rec_q.present_level <= ease_level;
						state_q             <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						if (!ign_q) begin
							vld_q[addr_q] <= 1'b1;
						end
						rsp_q.channel_out   <= req_q.channel;
						rsp_q.level         <= ign_q ? '0 : rec_q.present_level;
						rsp_q.is_running    <= !ign_q && rec_q.running;
						rsp_q.just_finished <= !ign_q && fin_q;
						rsp_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// a response only appears out of the write-back step
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside write-back");

	// a finishing tick never reports the channel as still running
	a_fin_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.is_running && rsp_q.just_finished))
		else $error("finished channel reported running");

	// write-back with a free slot always posts the response and frees the block
	a_done_posts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && slot_free) |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("write-back did not post response");

endmodule

/* design/etc_ram.sv */
// generic single-port-write, single-port-read memory with registered read data
// no dependencies
module etc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/etc_div.sv */
// bit-serial restoring divider forming t = (num << FRACTION_BITS) / den, num below den
// depends on etc_pkg for the default fraction width
module etc_div import etc_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [23:0]              num,
	input  logic [23:0]              den,
	output logic                     done,
	output logic [FRACTION_BITS-1:0] quot
);

	localparam int CW = $clog2(FRACTION_BITS + 1);

	logic [23:0]              rem_q;
	logic [23:0]              den_q;
	logic [FRACTION_BITS-1:0] quot_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [24:0]              shl;
	logic                     fits;

	assign shl  = {rem_q, 1'b0};
	assign fits = shl >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			rem_q  <= num;
			den_q  <= den;
			cnt_q  <= CW'(FRACTION_BITS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			// remainder stays below den, so 24 bits hold it
			rem_q  <= fits ? 24'(shl - {1'b0, den_q}) : shl[23:0];
			quot_q <= {quot_q[FRACTION_BITS-2:0], fits};
			cnt_q  <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* design/etc_ease.sv */
// easing sequencer: eased(t) for the five curves, then level = start + span * eased
// depends on etc_pkg; holds the sine and exp2 lookup roms for the elastic curve
module etc_ease import etc_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [FRACTION_BITS-1:0] t,
	input  logic [2:0]               curve,
	input  logic signed [31:0]       base,
	input  logic signed [31:0]       target,
	output logic                     done,
	output logic signed [31:0]       level
);

	localparam logic [2:0] CRV_OUT_QUAD     = 3'd1;
	localparam logic [2:0] CRV_IN_OUT_CUBIC = 3'd2;
	localparam logic [2:0] CRV_OUT_BOUNCE   = 3'd3;
	localparam logic [2:0] CRV_OUT_ELASTIC  = 3'd4;

	localparam int ONE     = 1 << FRACTION_BITS;
	localparam int MW      = FRACTION_BITS + 4;
	localparam int ES      = FRACTION_BITS + 3;
	localparam int SPW     = 33 + ES;
	localparam int TW      = $clog2(TABLE_ENTRIES);
	localparam int FPW     = FRACTION_BITS + $clog2(TABLE_ENTRIES + 1);
	localparam int VW      = $clog2(13 * TABLE_ENTRIES);
	localparam int YW      = FRACTION_BITS + VW;
	localparam int K3      = VW + 1;
	localparam int M3      = (1 << K3) / 3;
	localparam int QPW     = VW + K3;
	localparam int ELA_OFF = 9 * (ONE / 4);

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] Q30_PI      = 64'd3373259426;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
	localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
	localparam logic [63:0] Q30_LN2     = 64'd744261118;

	localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
	localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

	typedef logic [31:0] tab_t [TABLE_ENTRIES];

	// sin(2*pi*k/N) in Q2.30, truncating Taylor series over the first quadrant
	function automatic tab_t build_sin();
		tab_t        tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		logic        neg;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			x   = (64'(k) * Q30_TWO_PI) / 64'(TABLE_ENTRIES);
			neg = 1'b0;
			if (x > Q30_PI) begin
				x   = x - Q30_PI;
				neg = 1'b1;
			end
			if (x > Q30_HALF_PI) begin
				x = Q30_PI - x;
			end
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int i = 1; i <= 8; i++) begin
				term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
				if ((i & 1) != 0) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > longint'(Q30_ONE)) begin
				sum = longint'(Q30_ONE);
			end
			tab[k] = neg ? 32'(-sum) : 32'(sum);
		end
		return tab;
	endfunction

	// 2^(-k/N) in Q2.30 as e^(-ln2*k/N)
	function automatic tab_t build_exp2();
		tab_t        tab;
		logic [63:0] y;
		logic [63:0] t2;
		longint      s2;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			y  = (64'(k) * Q30_LN2) / 64'(TABLE_ENTRIES);
			t2 = Q30_ONE;
			s2 = longint'(Q30_ONE);
			for (int i = 1; i <= 12; i++) begin
				t2 = ((t2 * y) >> 30) / 64'(i);
				if ((i & 1) != 0) begin
					s2 = s2 - longint'(t2);
				end else begin
					s2 = s2 + longint'(t2);
				end
			end
			if (s2 < 0) begin
				s2 = 0;
			end
			if (s2 > longint'(Q30_ONE)) begin
				s2 = longint'(Q30_ONE);
			end
			tab[k] = 32'(s2);
		end
		return tab;
	endfunction

	localparam tab_t SIN_TAB  = build_sin();
	localparam tab_t EXP2_TAB = build_exp2();

	typedef enum logic [3:0] {
		E_IDLE,
		E_PREP,
		E_MUL,
		E_POST,
		E_ELA_Q,
		E_ELA_IDX,
		E_ELA_RD,
		E_ELA_TAB,
		E_ELA_MUL,
		E_ELA_POST,
		E_SCALE,
		E_SUM
	} est_t;

	est_t                     st_q;
	logic [FRACTION_BITS-1:0] t_q;
	logic [2:0]               crv_q;
	logic signed [31:0]       base_q;
	logic signed [32:0]       span_q;
	logic [MW-1:0]            opa_q;
	logic [MW-1:0]            opb_q;
	logic [2*MW-1:0]          prod_q;
	logic                     pass_q;
	logic                     low_q;
	logic                     bsh_q;
	logic [MW-1:0]            off_q;
	logic signed [ES-1:0]     ease_q;
	logic [YW-1:0]            y_q;
	logic [FPW-1:0]           fp_q;
	logic [3:0]               n_q;
	logic [VW-1:0]            v_q;
	logic [VW-1:0]            q0_q;
	logic [TW-1:0]            idx_q;
	logic [TW-1:0]            eidx_q;
	logic [31:0]              sin_q;
	logic [31:0]              exp_q;
	logic [30:0]              ex_q;
	logic [30:0]              sa_q;
	logic                     neg_q;
	logic [61:0]              eprod_q;
	logic signed [SPW-1:0]    sprod_q;
	logic signed [31:0]       level_q;
	logic                     done_q;

	// operand prep from t
	logic [MW-1:0]   u_w;
	logic [MW-1:0]   a_w;
	logic [MW-1:0]   t11_w;
	logic [MW:0]     t22_w;
	logic [MW-1:0]   ten_w;
	logic [MW-1:0]   bd_w;
	logic [MW-1:0]   boff_w;
	logic            bsh_w;
	logic [2*MW-1:0] bval_w;
	logic [MW-1:0]   c_w;
	logic [VW-1:0]   v_w;
	logic [QPW-1:0]  q3_w;
	logic [VW+1:0]   rem3_w;
	logic [VW-1:0]   q_w;
	logic [VW-1:0]   r_w;
	logic [FRACTION_BITS:0] mag_w;
	logic signed [SPW-FRACTION_BITS-1:0] shv_w;
	logic signed [36:0] sum_w;

	always_comb begin
		u_w   = MW'(ONE) - MW'(t_q);
		a_w   = t_q[FRACTION_BITS-1] ? MW'(2 * ONE) - MW'({t_q, 1'b0}) : MW'(t_q);
		t11_w = MW'(t_q) * MW'(11);
		t22_w = (MW+1)'(t_q) * (MW+1)'(22);
		ten_w = MW'(t_q) * MW'(10);

		// out-bounce segments
		bsh_w = 1'b0;
		if (t11_w < MW'(4 * ONE)) begin
			bd_w   = t11_w;
			boff_w = '0;
		end else if (t11_w < MW'(8 * ONE)) begin
			bd_w   = (t11_w >= MW'(6 * ONE)) ? t11_w - MW'(6 * ONE) : MW'(6 * ONE) - t11_w;
			boff_w = MW'(3 * (ONE / 4));
		end else if (t11_w < MW'(10 * ONE)) begin
			bd_w   = (t11_w >= MW'(9 * ONE)) ? t11_w - MW'(9 * ONE) : MW'(9 * ONE) - t11_w;
			boff_w = MW'(15 * (ONE / 16));
		end else begin
			bd_w   = (t22_w >= (MW+1)'(21 * ONE)) ? MW'(t22_w - (MW+1)'(21 * ONE))
				: MW'((MW+1)'(21 * ONE) - t22_w);
			boff_w = MW'(63 * (ONE / 64));
			bsh_w  = 1'b1;
		end

		bval_w = (bsh_q ? (prod_q >> (FRACTION_BITS + 6)) : (prod_q >> (FRACTION_BITS + 4)))
			+ (2*MW)'(off_q);
		c_w    = MW'(prod_q >> FRACTION_BITS);

		// phase index: floor(v / 3) by reciprocal, then mod N
		v_w    = y_q[YW-1:FRACTION_BITS];
		q3_w   = QPW'(v_w) * QPW'(M3);
		rem3_w = (VW+2)'(v_q) - (VW+2)'(q0_q) * (VW+2)'(3);
		q_w    = (rem3_w >= (VW+2)'(3)) ? q0_q + VW'(1) : q0_q;
		if (q_w >= VW'(4 * TABLE_ENTRIES)) begin
			r_w = q_w - VW'(4 * TABLE_ENTRIES);
		end else if (q_w >= VW'(3 * TABLE_ENTRIES)) begin
			r_w = q_w - VW'(3 * TABLE_ENTRIES);
		end else if (q_w >= VW'(2 * TABLE_ENTRIES)) begin
			r_w = q_w - VW'(2 * TABLE_ENTRIES);
		end else if (q_w >= VW'(TABLE_ENTRIES)) begin
			r_w = q_w - VW'(TABLE_ENTRIES);
		end else begin
			r_w = q_w;
		end

		mag_w = (FRACTION_BITS+1)'(eprod_q >> (60 - FRACTION_BITS));

		shv_w = sprod_q[SPW-1:FRACTION_BITS];
		sum_w = 37'(base_q) + 37'(shv_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= E_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				E_IDLE: begin
					if (start) begin
						t_q    <= t;
						crv_q  <= curve;
						base_q <= base;
						span_q <= 33'(target) - 33'(base);
						pass_q <= 1'b0;
						st_q   <= E_PREP;
					end
				end
				E_PREP: begin
					case (crv_q)
						CRV_OUT_QUAD: begin
							opa_q <= u_w;
							opb_q <= u_w;
							st_q  <= E_MUL;
						end
						CRV_IN_OUT_CUBIC: begin
							opa_q <= a_w;
							opb_q <= a_w;
							low_q <= !t_q[FRACTION_BITS-1];
							st_q  <= E_MUL;
						end
						CRV_OUT_BOUNCE: begin
							opa_q <= bd_w;
							opb_q <= bd_w;
							off_q <= boff_w;
							bsh_q <= bsh_w;
							st_q  <= E_MUL;
						end
						CRV_OUT_ELASTIC: begin
							if (t_q == '0) begin
								ease_q <= '0;
								st_q   <= E_SCALE;
							end else begin
								y_q  <= YW'(ten_w + MW'(ELA_OFF)) * YW'(TABLE_ENTRIES);
								fp_q <= FPW'(ten_w[FRACTION_BITS-1:0]) * FPW'(TABLE_ENTRIES);
								n_q  <= ten_w[MW-1:FRACTION_BITS];
								st_q <= E_ELA_Q;
							end
						end
						default: begin
							// linear, and the unused kinds
							ease_q <= ES'(t_q);
							st_q   <= E_SCALE;
						end
					endcase
				end
				E_MUL: begin
					prod_q <= (2*MW)'(opa_q) * (2*MW)'(opb_q);
					st_q   <= E_POST;
				end
				E_POST: begin
					case (crv_q)
						CRV_OUT_QUAD: begin
							ease_q <= ES'(ONE) - ES'(c_w);
							st_q   <= E_SCALE;
						end
						CRV_IN_OUT_CUBIC: begin
							if (!pass_q) begin
								opa_q  <= c_w;
								pass_q <= 1'b1;
								st_q   <= E_MUL;
							end else begin
								ease_q <= low_q ? ES'({c_w, 2'b00}) : ES'(ONE) - ES'(c_w >> 1);
								st_q   <= E_SCALE;
							end
						end
						default: begin
							ease_q <= ES'(bval_w);
							st_q   <= E_SCALE;
						end
					endcase
				end
				E_ELA_Q: begin
					v_q  <= v_w;
					q0_q <= VW'(q3_w >> K3);
					st_q <= E_ELA_IDX;
				end
				E_ELA_IDX: begin
					idx_q  <= TW'(r_w);
					eidx_q <= fp_q[FRACTION_BITS +: TW];
					st_q   <= E_ELA_RD;
				end
				E_ELA_RD: begin
					sin_q <= SIN_TAB[idx_q];
					exp_q <= EXP2_TAB[eidx_q];
					st_q  <= E_ELA_TAB;
				end
				E_ELA_TAB: begin
					ex_q  <= 31'(exp_q >> n_q);
					sa_q  <= sin_q[31] ? 31'(-sin_q) : 31'(sin_q);
					neg_q <= sin_q[31];
					st_q  <= E_ELA_MUL;
				end
				E_ELA_MUL: begin
					eprod_q <= 62'(ex_q) * 62'(sa_q);
					st_q    <= E_ELA_POST;
				end
				E_ELA_POST: begin
					ease_q <= neg_q ? ES'(ONE) - ES'(mag_w) : ES'(ONE) + ES'(mag_w);
					st_q   <= E_SCALE;
				end
				E_SCALE: begin
					sprod_q <= SPW'(span_q) * SPW'(ease_q);
					st_q    <= E_SUM;
				end
				E_SUM: begin
					if (sum_w > SAT_MAX) begin
						level_q <= 32'sh7FFFFFFF;
					end else if (sum_w < SAT_MIN) begin
						level_q <= 32'sh80000000;
					end else begin
						level_q <= 32'(sum_w);
					end
					done_q <= 1'b1;
					st_q   <= E_IDLE;
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign level = level_q;

endmodule

/* bench/tween_scoreboard.sv */
// watches the request and response sides of the tween block, forecasts each response and compares it
// depends on etc_pkg for the request and response types
module tween_scoreboard import etc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	input  logic req_stall,
	input  rsp_t rsp,
	input  logic rsp_valid,
	input  logic rsp_stall,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH   = 8;
	localparam int TABN  = 1024;
	localparam int FB    = 16;
	localparam longint ONE = 64'd1 << FB;
	localparam bit [63:0] Q30_ONE     = 64'd1073741824;
	localparam bit [63:0] Q30_PI      = 64'd3373259426;
	localparam bit [63:0] Q30_HALF_PI = 64'd1686629713;
	localparam bit [63:0] Q30_TWO_PI  = 64'd6746518852;
	localparam bit [63:0] Q30_LN2     = 64'd744261118;

	longint sine_q30[TABN];
	longint decay_q30[TABN];

	logic signed [31:0] from_lvl[NCH];
	logic signed [31:0] to_lvl[NCH];
	logic signed [31:0] now_lvl[NCH];
	logic [23:0]        len_us[NCH];
	logic [23:0]        gone_us[NCH];
	logic               playing[NCH];
	logic [2:0]         shape[NCH];

	rsp_t awaited_levels[$];

	// sine and 2^-x tables, truncating taylor series in q2.30
	initial begin
		bit [63:0] x, x2, term, y, t2;
		longint sum, s2;
		bit neg;
		for (int k = 0; k < TABN; k++) begin
			x = (64'(k) * Q30_TWO_PI) / TABN;
			neg = 0;
			if (x > Q30_PI) begin
				x -= Q30_PI;
				neg = 1;
			end
			if (x > Q30_HALF_PI) x = Q30_PI - x;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int i = 1; i <= 8; i++) begin
				term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
				if (i & 1) sum -= longint'(term);
				else sum += longint'(term);
			end
			if (sum < 0) sum = 0;
			if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
			sine_q30[k] = neg ? -sum : sum;
			y = (64'(k) * Q30_LN2) / TABN;
			t2 = Q30_ONE;
			s2 = longint'(Q30_ONE);
			for (int i = 1; i <= 12; i++) begin
				t2 = ((t2 * y) >> 30) / 64'(i);
				if (i & 1) s2 -= longint'(t2);
				else s2 += longint'(t2);
			end
			if (s2 < 0) s2 = 0;
			if (s2 > longint'(Q30_ONE)) s2 = longint'(Q30_ONE);
			decay_q30[k] = s2;
		end
	end

	function automatic longint ease(bit [63:0] t, logic [2:0] kind);
		bit [63:0] one, u, w, c, sq, t11, d, ten, idx, eidx, e, mag;
		longint s;
		int n;
		one = ONE;
		case (kind)
			3'd1: begin
				u = one - t;
				return longint'(one - ((u * u) >> FB));
			end
			3'd2: begin
				if (2 * t < one) begin
					sq = (t * t) >> FB;
					return longint'(4 * ((sq * t) >> FB));
				end
				w = 2 * one - 2 * t;
				c = (((w * w) >> FB) * w) >> FB;
				return longint'(one) - longint'(c >> 1);
			end
			3'd3: begin
				t11 = 11 * t;
				if (t11 < 4 * one) return longint'((121 * t * t) >> (FB + 4));
				if (t11 < 8 * one) begin
					d = (t11 < 6 * one) ? 6 * one - t11 : t11 - 6 * one;
					return longint'(((d * d) >> (FB + 4)) + 3 * (one >> 2));
				end
				if (t11 < 10 * one) begin
					d = (t11 >= 9 * one) ? t11 - 9 * one : 9 * one - t11;
					return longint'(((d * d) >> (FB + 4)) + 15 * (one >> 4));
				end
				d = (22 * t >= 21 * one) ? 22 * t - 21 * one : 21 * one - 22 * t;
				return longint'(((d * d) >> (FB + 6)) + 63 * (one >> 6));
			end
			3'd4: begin
				if (t == 0) return 0;
				ten = 10 * t;
				idx = ((ten + 9 * (one >> 2)) * TABN) / (3 * one);
				idx = idx % TABN;
				n = int'(ten >> FB);
				eidx = ((ten & (one - 1)) * TABN) >> FB;
				if (eidx >= TABN) eidx = TABN - 1;
				if (n > 40) n = 40;
				e = 64'(decay_q30[eidx]) >> n;
				s = sine_q30[idx];
				mag = (e * 64'(s < 0 ? -s : s)) >> (60 - FB);
				return s < 0 ? longint'(one) - longint'(mag) : longint'(one + mag);
			end
			default: return longint'(t);
		endcase
	endfunction

	// applies one request to the channel bank and returns the response it should give
	function automatic rsp_t advance_channel(req_t r);
		rsp_t o;
		int unsigned ch, p;
		bit [63:0] t;
		longint span, v;
		ch = r.channel;
		o.channel_out = r.channel;
		o.just_finished = 1'b0;
		case (r.opcode)
			OP_TICK: begin
				if (playing[ch]) begin
					p = 32'(gone_us[ch]) + 32'(r.delta_us);
					if (p > len_us[ch]) p = len_us[ch];
					gone_us[ch] = p[23:0];
					if (p >= len_us[ch]) begin
						now_lvl[ch] = to_lvl[ch];
						playing[ch] = 1'b0;
						o.just_finished = 1'b1;
					end else begin
						t = (64'(p) << FB) / 64'(len_us[ch]);
						span = longint'(to_lvl[ch]) - longint'(from_lvl[ch]);
						v = longint'(from_lvl[ch]) + ((span * ease(t, shape[ch])) >>> FB);
						if (v > 64'sd2147483647) v = 64'sd2147483647;
						if (v < -64'sd2147483648) v = -64'sd2147483648;
						now_lvl[ch] = v[31:0];
					end
				end
			end
			OP_START: begin
				from_lvl[ch] = r.start_value;
				to_lvl[ch]   = r.end_value;
				now_lvl[ch]  = r.start_value;
				len_us[ch]   = r.duration_us;
				gone_us[ch]  = '0;
				playing[ch]  = 1'b1;
				shape[ch]    = r.curve_kind;
			end
			OP_STOP: playing[ch] = 1'b0;
			default: begin
				from_lvl[ch] = r.start_value;
				to_lvl[ch]   = r.start_value;
				now_lvl[ch]  = r.start_value;
				gone_us[ch]  = '0;
				playing[ch]  = 1'b0;
			end
		endcase
		o.level = now_lvl[ch];
		o.is_running = playing[ch];
		return o;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d, want %0d", what, got, want);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				from_lvl[i] = '0;
				to_lvl[i]   = '0;
				now_lvl[i]  = '0;
				len_us[i]   = '0;
				gone_us[i]  = '0;
				playing[i]  = 1'b0;
				shape[i]    = '0;
			end
			awaited_levels.delete();
		end else begin
			if (req_valid && !req_stall) awaited_levels.push_back(advance_channel(req));
			if (rsp_valid && !rsp_stall) begin
				if (awaited_levels.size() == 0) begin
					report("unexpected response, channel", rsp.channel_out, -1);
				end else begin
					want = awaited_levels.pop_front();
					if (rsp.channel_out !== want.channel_out)
						report("channel_out", rsp.channel_out, want.channel_out);
					if (rsp.level !== want.level) report("level", rsp.level, want.level);
					if (rsp.is_running !== want.is_running)
						report("is_running", rsp.is_running, want.is_running);
					if (rsp.just_finished !== want.just_finished)
						report("just_finished", rsp.just_finished, want.just_finished);
				end
			end
		end
		pending = awaited_levels.size();
	end

	initial pending = 0;

endmodule

/* bench/tb_eased_tween_channels.sv */
// top of the tween block bench: clock, reset, request stimulus and response stalls
// depends on etc_pkg, eased_tween_channels and tween_scoreboard
module tb_eased_tween_channels;
	import etc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	req_t req;
	logic req_valid;
	logic req_stall;
	rsp_t rsp;
	logic rsp_valid;
	logic rsp_stall;
	int   errors;
	int   pending;
	int   burst_left;
	int   idle_cycles;

	eased_tween_channels i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	tween_scoreboard i_scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic req_t mk(op_t op, int ch, logic [31:0] sv, logic [31:0] ev,
			logic [23:0] dur, logic [2:0] kind, logic [23:0] delta);
		req_t r;
		r.opcode = op;
		r.channel = ch[2:0];
		r.start_value = sv;
		r.end_value = ev;
		r.duration_us = dur;
		r.curve_kind = kind;
		r.delta_us = delta;
		return r;
	endfunction

	// called at a rising edge; returns at the edge where the request was taken, or after a random pause with req_valid low
	task automatic send(req_t r);
		req <= r;
		req_valid <= 1'b1;
		do @(negedge clk); while (req_stall);
		@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	endtask

	function automatic logic [31:0] any_level();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 200000) - 100000;
			1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7fffffff} ^ 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [23:0] any_length();
		case ($urandom_range(0, 9))
			0: return 24'd0;
			1, 2: return 24'($urandom);
			default: return 24'($urandom_range(1, 3000));
		endcase
	endfunction

	function automatic logic [23:0] any_step();
		case ($urandom_range(0, 9))
			0: return 24'($urandom);
			1: return 24'd0;
			default: return 24'($urandom_range(1, 400));
		endcase
	endfunction

	function automatic req_t any_request(int ch);
		op_t op;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: op = OP_TICK;
			5, 6: op = OP_START;
			7: op = OP_STOP;
			default: op = OP_SNAP;
		endcase
		return mk(op, ch, any_level(), any_level(), any_length(), 3'($urandom_range(0, 7)),
			any_step());
	endfunction

	initial begin
		int count, ch, ticks;
		arst_n = 1'b0;
		req = '0;
		req_valid = 1'b0;
		burst_left = 4;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, zero length, idle tick, stop and snap
		send(mk(OP_TICK, 0, 0, 0, 0, 0, 24'hffffff));
		send(mk(OP_START, 0, 32'h80000000, 32'h7fffffff, 24'hffffff, 0, 0));
		send(mk(OP_TICK, 0, 0, 0, 0, 0, 24'd0));
		send(mk(OP_TICK, 0, 0, 0, 0, 0, 24'h7fffff));
		send(mk(OP_TICK, 0, 0, 0, 0, 0, 24'hffffff));
		send(mk(OP_START, 7, 32'h7fffffff, 32'h80000000, 24'd0, 3'd7, 0));
		send(mk(OP_TICK, 7, 0, 0, 0, 0, 24'd0));
		send(mk(OP_START, 3, 32'h00010000, 32'h00050000, 24'd100, 3'd4, 0));
		send(mk(OP_TICK, 3, 0, 0, 0, 0, 24'd1));
		send(mk(OP_STOP, 3, 0, 0, 0, 0, 0));
		send(mk(OP_TICK, 3, 0, 0, 0, 0, 24'd10));
		send(mk(OP_SNAP, 3, 32'hfffe0000, 32'h12345678, 24'd5, 3'd2, 0));
		send(mk(OP_TICK, 3, 0, 0, 0, 0, 24'd10));
		// every curve kind, including the ones eased as linear
		for (int k = 0; k < 8; k++) begin
			send(mk(OP_START, k, 32'hffff0000, 32'h00640000, 24'd1000, 3'(k), 0));
			send(mk(OP_TICK, k, 0, 0, 0, 0, 24'(330 + k * 40)));
		end

		count = 0;
		while (count < 1800) begin
			ch = $urandom_range(0, 7);
			if ($urandom_range(0, 9) < 7) begin
				// start followed by a run of ticks on the same channel, mixed with random requests on any channel
				send(mk(OP_START, ch, any_level(), any_level(), any_length(),
					3'($urandom_range(0, 7)), 24'($urandom)));
				ticks = $urandom_range(2, 14);
				count++;
				for (int i = 0; i < ticks; i++) begin
					if ($urandom_range(0, 4) == 0) send(any_request($urandom_range(0, 7)));
					else send(mk(OP_TICK, ch, $urandom, $urandom, 24'($urandom),
						3'($urandom), any_step()));
					count++;
				end
			end else begin
				send(any_request(ch));
				count++;
			end
		end
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) $display("tb_eased_tween_channels: done, clean");
		else $display("tb_eased_tween_channels: done, errors");
		$finish;
	end

	// receiver: stall pattern changes every so often, plus one long hold-off
	initial begin
		int cyc, mode, left;
		cyc = 0;
		mode = 0;
		left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(32, 256);
			end
			left--;
			if (cyc >= 3000 && cyc < 3800) rsp_stall <= 1'b1;
			else case (mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 9) < 3);
				2: rsp_stall <= ($urandom_range(0, 9) < 8);
				default: rsp_stall <= cyc[2];
			endcase
		end
	end

	// watchdog on cycles with no request or response taken
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_eased_tween_channels: done, errors");
				$finish;
			end
		end
	end

endmodule
